/* design/segment_intersection_macros.svh */
// Assertion macros for the segment intersection checker.
// Depends on clk_i and rst_ni in the scope of use.
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH
// Concurrent assertion, sampled on clk_i and off during reset.
`define SI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Concurrent assertion that also holds during reset.
`define SI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

/* design/si_pkg.sv */
// Package for the segment intersection block: constants and pipeline types.
// No dependencies.
`timescale 1ns / 1ps
package si_pkg;
  localparam int COORD_FRAC_BITS = 12;
  localparam int CW = 24;
  localparam int VW = 25;
  localparam int PW = 50;
  localparam int XW = 51;
  localparam int DW = 52;
  localparam int QW = 16;

  typedef struct packed {
    logic              vld;
    logic              go;
    logic signed [CW-1:0] sax;
    logic signed [CW-1:0] say;
    logic signed [VW-1:0] ax;
    logic signed [VW-1:0] ay;
  } si_pay_t;

  typedef struct packed {
    si_pay_t       pay;
    logic [DW-1:0] r;
    logic [DW-1:0] d;
    logic [QW-1:0] q;
  } si_div_t;
endpackage

/* design/si_front.sv */
// Front pipeline: direction vectors, cross products, sign normalization and
// parallel and range tests. Depends on si_pkg.
`timescale 1ns / 1ps
module si_front #(
  parameter int CoordFracBits = si_pkg::COORD_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [8*si_pkg::CW-1:0] data_i,
  output si_pkg::si_div_t       div_o
);
  import si_pkg::*;

  localparam logic [59:0] Limit = 60'(1) << (2 * CoordFracBits);

  si_pay_t p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  si_pay_t p6_d;
  logic signed [VW-1:0] bx_q, by_q, dx_q, dy_q;
  logic signed [PW-1:0] m_q [6];
  logic signed [XW-1:0] den_q, ns_q, nu_q;
  logic [DW-1:0] dn_q, dn5_q;
  logic signed [DW-1:0] nsn_q, nun_q, nsn5_q;
  logic par_q, lts_q, ltu_q;
  logic [65:0] ms_q, mu_q;
  logic [DW-1:0] r6_q, d6_q;

  logic signed [CW-1:0] c [8];
  logic signed [XW-1:0] den_w;
  logic signed [DW-1:0] dw, sw, uw;
  logic [65:0] xs, xu;
  logic [59:0] mag100;

  always_comb begin
    for (int i = 0; i < 8; i++) c[i] = data_i[i*CW +: CW];
    den_w  = den_q;
    dw     = DW'(den_q);
    sw     = DW'(ns_q);
    uw     = DW'(nu_q);
    xs     = 66'(nsn_q[DW-1:0]);
    xu     = 66'(nun_q[DW-1:0]);
    mag100 = (60'(dn_q) << 6) + (60'(dn_q) << 5) + (60'(dn_q) << 2);
    p6_d    = p5_q;
    p6_d.go = p5_q.vld && !par_q && lts_q && ltu_q
              && (ms_q > 66'(dn5_q)) && (mu_q > 66'(dn5_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0; p2_q <= '0; p3_q <= '0; p4_q <= '0; p5_q <= '0; p6_q <= '0;
    end else if (en_i) begin
      p1_q.vld <= vld_i;
      p1_q.go  <= 1'b0;
      p1_q.sax <= c[0];
      p1_q.say <= c[1];
      p1_q.ax  <= VW'(c[2]) - VW'(c[0]);
      p1_q.ay  <= VW'(c[3]) - VW'(c[1]);
      p2_q <= p1_q;
      p3_q <= p2_q;
      p4_q <= p3_q;
      p5_q <= p4_q;
      p6_q <= p6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx_q <= VW'(c[6]) - VW'(c[4]);
      by_q <= VW'(c[7]) - VW'(c[5]);
      dx_q <= VW'(c[4]) - VW'(c[0]);
      dy_q <= VW'(c[5]) - VW'(c[1]);
      m_q[0] <= p1_q.ax * by_q;
      m_q[1] <= p1_q.ay * bx_q;
      m_q[2] <= dx_q * by_q;
      m_q[3] <= dy_q * bx_q;
      m_q[4] <= dx_q * p1_q.ay;
      m_q[5] <= dy_q * p1_q.ax;
      den_q <= XW'(m_q[0]) - XW'(m_q[1]);
      ns_q  <= XW'(m_q[2]) - XW'(m_q[3]);
      nu_q  <= XW'(m_q[4]) - XW'(m_q[5]);
      dn_q  <= den_w[XW-1] ? DW'(-dw) : DW'(dw);
      nsn_q <= den_w[XW-1] ? -sw : sw;
      nun_q <= den_w[XW-1] ? -uw : uw;
      par_q  <= mag100 <= Limit;
      lts_q  <= (nsn_q > 0) && (nsn_q < $signed(dn_q));
      ltu_q  <= (nun_q > 0) && (nun_q < $signed(dn_q));
      ms_q   <= (xs << 13) + (xs << 10) + (xs << 9) + (xs << 8) + (xs << 4);
      mu_q   <= (xu << 13) + (xu << 10) + (xu << 9) + (xu << 8) + (xu << 4);
      dn5_q  <= dn_q;
      nsn5_q <= nsn_q;
      r6_q   <= nsn5_q[DW-1:0];
      d6_q   <= dn5_q;
    end
  end

  always_comb begin
    div_o.pay = p6_q;
    div_o.r   = r6_q;
    div_o.d   = d6_q;
    div_o.q   = '0;
  end
endmodule

/* design/si_div_cell.sv */
// One restoring division cell: produces one quotient bit and hands the
// remainder, divisor and payload to the next cell. Depends on si_pkg.
`timescale 1ns / 1ps
module si_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  si_pkg::si_div_t d_i,
  output si_pkg::si_div_t d_o
);
  import si_pkg::*;

  logic [DW-1:0] r2;
  logic          take;
  si_pay_t       pay_q;
  logic [DW-1:0] r_q, dv_q;
  logic [QW-1:0] q_q;

  always_comb begin
    r2   = {d_i.r[DW-2:0], 1'b0};
    take = r2 >= d_i.d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pay_q <= '0;
    end else if (en_i) begin
      pay_q <= d_i.pay;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q  <= take ? r2 - d_i.d : r2;
      dv_q <= d_i.d;
      q_q  <= {d_i.q[QW-2:0], take};
    end
  end

  always_comb begin
    d_o.pay = pay_q;
    d_o.r   = r_q;
    d_o.d   = dv_q;
    d_o.q   = q_q;
  end
endmodule

/* design/segment_intersection.sv */
// Six front stages, a chain of 16 division cells (one quotient bit each),
// one point stage and the output register; one item per cycle, all stages advance together.
// The whole pipeline stalls while a result waits at the output.
// Reset clears all valid flags and payload registers asynchronously; other data registers are not reset.
`timescale 1ns / 1ps
module segment_intersection #(
  parameter int CoordFracBits = si_pkg::COORD_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [8*si_pkg::CW-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // param_s, cross_x, cross_y
  output logic [63:0]             m_axis_tdata,
  // hit
  output logic                    m_axis_tuser
);
  import si_pkg::*;

  logic    en;
  si_div_t chain [QW+1];
  si_pay_t pp_q;
  logic [QW-1:0] q_q;
  logic signed [41:0] px_q, py_q;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  si_front #(.CoordFracBits(CoordFracBits)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid), .data_i(s_axis_tdata),
    .div_o(chain[0])
  );

  for (genvar g = 0; g < QW; g++) begin : g_div
    si_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .d_i(chain[g]), .d_o(chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q          <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tuser  <= 1'b0;
    end else if (en) begin
      pp_q          <= chain[QW].pay;
      m_axis_tvalid <= pp_q.vld;
      m_axis_tuser  <= pp_q.go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q  <= chain[QW].q;
      px_q <= chain[QW].pay.ax * $signed({1'b0, chain[QW].q});
      py_q <= chain[QW].pay.ay * $signed({1'b0, chain[QW].q});
      if (pp_q.go) begin
        m_axis_tdata <= {pp_q.say + py_q[39:16], pp_q.sax + px_q[39:16], q_q};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end
endmodule

/* design/si_checker.sv */
// Port-level checker for segment_intersection, bound to the top level.
// Depends on segment_intersection_macros.svh.
`timescale 1ns / 1ps
`include "segment_intersection_macros.svh"
module si_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  `SI_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `SI_ASSERT(a_nohit, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0, "miss with nonzero data")
  `SI_ASSERT(a_hit, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] != 16'd0, "hit with zero param")
  `SI_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready out of step")
  `SI_ASSERT_ALWAYS(a_rst, !rst_ni |-> !m_axis_tvalid, "result valid in reset")
endmodule

bind segment_intersection si_checker u_si_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
